@@ rtl/hsv_fader_to_rgb_assert.svh @@
// Assertion macros for the checker module.
`ifndef HSV_FADER_TO_RGB_ASSERT_SVH
`define HSV_FADER_TO_RGB_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HFTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hftr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HFTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hftr check failed");

`endif

@@ rtl/hftr_pkg.sv @@
`timescale 1ns / 1ps

package hftr_pkg;

    localparam int CHAN_W = 8;
    localparam int PROD_W = 2 * CHAN_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SATURATION  = 2'd0;
    localparam cfg_idx_t CFG_HUE_LIMIT   = 2'd1;
    localparam cfg_idx_t CFG_LEVEL_LIMIT = 2'd2;

    localparam chan_t SATURATION_RST  = 8'd255;
    localparam chan_t HUE_LIMIT_RST   = 8'd191;
    localparam chan_t LEVEL_LIMIT_RST = 8'd255;

    localparam logic FUNC_FADE = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

endpackage

@@ rtl/hftr_in_if.sv @@
`timescale 1ns / 1ps

interface hftr_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic signed [7:0]   hue_step;
    logic signed [7:0]   level_step;
    hftr_pkg::chan_t     new_hue;
    hftr_pkg::chan_t     new_level;

    modport source (output valid, func, hue_step, level_step, new_hue, new_level,
                    input ready);
    modport sink   (input valid, func, hue_step, level_step, new_hue, new_level,
                    output ready);
endinterface

@@ rtl/hftr_out_if.sv @@
`timescale 1ns / 1ps

interface hftr_out_if;
    logic            valid;
    logic            ready;
    hftr_pkg::chan_t red;
    hftr_pkg::chan_t green;
    hftr_pkg::chan_t blue;
    logic            lit;

    modport source (output valid, red, green, blue, lit, input ready);
    modport sink   (input valid, red, green, blue, lit, output ready);
endinterface

@@ rtl/hsv_fader_to_rgb.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// fade_in   in   valid/ready   func, hue_step, level_step, new_hue, new_level
// rgb_out   out  valid/ready   red, green, blue, lit
// cfg       in   cfg_we        cfg_index (2b), cfg_data (8b), no read-back
//
// For each item, the accept cycle updates hue and level, then three products
// (floor, up ramp, down ramp) pass one after another through the single
// registered 8x8 multiplier, and the FIN state loads rgb_out.
// fade_in.ready is high only in IDLE; a stalled rgb_out holds its item and the
// next result waits in FIN until the slot frees. rst_n is asynchronous; it clears
// the sequencer and output valid and restores the register defaults.
module hsv_fader_to_rgb (
    input  logic                clk,
    input  logic                rst_n,
    hftr_in_if.sink             fade_in,
    hftr_out_if.source          rgb_out,
    input  logic                cfg_we,
    input  hftr_pkg::cfg_idx_t  cfg_index,
    input  hftr_pkg::chan_t     cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL0 = 6'b000010,   // level * (255 - sat)
        ST_MUL1 = 6'b000100,   // offset * amp, latch floor
        ST_MUL2 = 6'b001000,   // (63 - offset) * amp, latch up
        ST_MUL3 = 6'b010000,   // latch down
        ST_FIN  = 6'b100000    // load output register
    } state_t;

    state_t state_reg, state_next;

    hftr_pkg::chan_t saturation_reg, hue_limit_reg, level_limit_reg;
    hftr_pkg::chan_t hue_reg, level_reg;
    logic            lit_reg;
    hftr_pkg::chan_t floor_reg, up_reg, down_reg;

    logic            out_valid_reg;
    hftr_pkg::chan_t red_reg, green_reg, blue_reg;
    logic            out_lit_reg;

    hftr_pkg::chan_t mul_a, mul_b;
    hftr_pkg::prod_t mul_p;

    logic            in_fire;
    logic            out_free;

    // Next hue / level / lit from the incoming item
    logic signed [9:0] hsum, lsum;
    logic signed [9:0] hue_lim_s, lvl_lim_s;
    hftr_pkg::chan_t   hue_new, level_new;
    logic              lit_new;

    hftr_pkg::chan_t   floor_now, amp_now, amp_reg_view, ramp_now;
    hftr_pkg::chan_t   red_sel, green_sel, blue_sel;

    assign in_fire  = fade_in.valid && fade_in.ready;
    assign out_free = !out_valid_reg || rgb_out.ready;
    assign fade_in.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        hsum      = $signed({2'b00, hue_reg}) + 10'(fade_in.hue_step);
        lsum      = $signed({2'b00, level_reg}) + 10'(fade_in.level_step);
        hue_lim_s = $signed({2'b00, hue_limit_reg});
        lvl_lim_s = $signed({2'b00, level_limit_reg});
        if (fade_in.func == hftr_pkg::FUNC_LOAD)
        begin
            hue_new   = fade_in.new_hue;
            level_new = fade_in.new_level;
            lit_new   = (fade_in.new_level != 8'd0);
        end
        else
        begin
            // wrap past the limit, then modulo 256
            if (hsum > hue_lim_s)
                hue_new = 8'(hsum - hue_lim_s);
            else
                hue_new = hsum[7:0];
            if (fade_in.level_step > 8'sd0)
            begin
                level_new = (lsum <= lvl_lim_s) ? lsum[7:0] : level_limit_reg;
                lit_new   = 1'b1;
            end
            else if (lsum > 10'sd0)
            begin
                level_new = lsum[7:0];
                lit_new   = 1'b1;
            end
            else
            begin
                level_new = 8'd0;
                lit_new   = 1'b0;
            end
        end
    end

    // Shared multiplier operand select
    assign floor_now    = mul_p[15:8];
    assign amp_now      = level_reg - floor_now;
    assign amp_reg_view = level_reg - floor_reg;
    assign ramp_now     = mul_p[13:6] + floor_reg;

    always_comb
    begin
        case (state_reg)
            ST_MUL0:
            begin
                mul_a = level_reg;
                mul_b = ~saturation_reg;
            end
            ST_MUL1:
            begin
                mul_a = {2'b00, hue_reg[5:0]};
                mul_b = amp_now;
            end
            ST_MUL2:
            begin
                mul_a = {2'b00, ~hue_reg[5:0]};
                mul_b = amp_reg_view;
            end
            default:
            begin
                mul_a = 8'd0;
                mul_b = 8'd0;
            end
        endcase
    end

    hftr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Section routing; hues 128 and up use the third section
    always_comb
    begin
        case (hue_reg[7:6])
            2'd0:
            begin
                red_sel = down_reg; green_sel = up_reg; blue_sel = floor_reg;
            end
            2'd1:
            begin
                red_sel = floor_reg; green_sel = down_reg; blue_sel = up_reg;
            end
            default:
            begin
                red_sel = up_reg; green_sel = floor_reg; blue_sel = down_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = in_fire ? ST_MUL0 : ST_IDLE;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_FIN;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            saturation_reg  <= hftr_pkg::SATURATION_RST;
            hue_limit_reg   <= hftr_pkg::HUE_LIMIT_RST;
            level_limit_reg <= hftr_pkg::LEVEL_LIMIT_RST;
            hue_reg         <= 8'd0;
            level_reg       <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hftr_pkg::CFG_SATURATION:  saturation_reg  <= cfg_data;
                    hftr_pkg::CFG_HUE_LIMIT:   hue_limit_reg   <= cfg_data;
                    hftr_pkg::CFG_LEVEL_LIMIT: level_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                hue_reg   <= hue_new;
                level_reg <= level_new;
            end
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (rgb_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            lit_reg <= lit_new;
        if (state_reg == ST_MUL1)
            floor_reg <= floor_now;
        if (state_reg == ST_MUL2)
            up_reg <= ramp_now;
        if (state_reg == ST_MUL3)
            down_reg <= ramp_now;
        if (state_reg == ST_FIN && out_free)
        begin
            red_reg     <= red_sel;
            green_reg   <= green_sel;
            blue_reg    <= blue_sel;
            out_lit_reg <= lit_reg;
        end
    end

    assign rgb_out.valid = out_valid_reg;
    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;
    assign rgb_out.lit   = out_lit_reg;

endmodule

@@ rtl/hftr_mul.sv @@
`timescale 1ns / 1ps

// Shared 8x8 unsigned multiplier, product registered.
module hftr_mul (
    input  logic            clk,
    input  hftr_pkg::chan_t a,
    input  hftr_pkg::chan_t b,
    output hftr_pkg::prod_t p
);

    hftr_pkg::prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= hftr_pkg::PROD_W'(a) * hftr_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

@@ rtl/hftr_checker.sv @@
`timescale 1ns / 1ps
`include "hsv_fader_to_rgb_assert.svh"

module hftr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input hftr_pkg::chan_t red,
    input hftr_pkg::chan_t green,
    input hftr_pkg::chan_t blue,
    input logic            lit
);

    // result item holds until taken
    `HFTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // block is busy right after taking an item
    `HFTR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // no result can appear the cycle after an accept
    `HFTR_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))
    // zero level gives black
    `HFTR_ASSERT_NOW(a_unlit_black, out_valid && !lit,
        red == 8'd0 && green == 8'd0 && blue == 8'd0)

endmodule

bind hsv_fader_to_rgb hftr_checker u_hftr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fade_in.valid),
    .in_ready  (fade_in.ready),
    .out_valid (rgb_out.valid),
    .out_ready (rgb_out.ready),
    .red       (rgb_out.red),
    .green     (rgb_out.green),
    .blue      (rgb_out.blue),
    .lit       (rgb_out.lit)
);
